/* hdl/tdlp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdlp_pkg
// Shared types, constants and the quarter-wave sine table for the truncated
// DFT low-pass core.
// ----------------------------------------------------------------------------
package tdlp_pkg;

	localparam int MaxSamples = 64;
	localparam int MaxBins    = 16;
	localparam int PhaseBits  = 16;

	localparam int BinW  = 23;	// bin range is +/- 2^21
	localparam int ProdW = BinW + 16;
	localparam int AccW  = 46;

	localparam logic [1:0] REG_NUM_SAMPLES = 2'd0;
	localparam logic [1:0] REG_NUM_BINS    = 2'd1;
	localparam logic [1:0] REG_PHASE_STEP  = 2'd2;
	localparam logic [1:0] REG_INV_SCALE   = 2'd3;

	localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

	typedef logic [15:0] sine_tab_t [256];

	// quarter-wave table built from a Q30 Taylor series
	function automatic sine_tab_t build_sine();
		sine_tab_t    tab;
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  t;
		logic signed [63:0] s;
		logic [63:0]  r;
		for (int i = 0; i < 256; i++) begin
			x  = (HalfPiQ30 * 64'(i)) >> 8;
			x2 = (x * x) >> 30;
			t  = ((x * x2) >> 30) / 64'd6;
			s  = $signed(x) - $signed(t);
			t  = ((t * x2) >> 30) / 64'd20;
			s  = s + $signed(t);
			t  = ((t * x2) >> 30) / 64'd42;
			s  = s - $signed(t);
			t  = ((t * x2) >> 30) / 64'd72;
			s  = s + $signed(t);
			t  = ((t * x2) >> 30) / 64'd110;
			s  = s - $signed(t);
			t  = ((t * x2) >> 30) / 64'd156;
			s  = s + $signed(t);
			if (s < 0) begin
				s = 64'sd0;
			end
			r = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
			tab[i] = r[15:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SineTable = build_sine();

	// signed Q1.15 sine of a full-turn phase word
	function automatic logic signed [15:0] sine_of(input logic [PhaseBits-1:0] ph);
		logic [1:0]  quad;
		logic [7:0]  idx;
		logic [8:0]  j;
		logic [15:0] mag;
		quad = ph[PhaseBits-1 -: 2];
		idx  = ph[PhaseBits-3 -: 8];
		j    = quad[0] ? (9'd256 - {1'b0, idx}) : {1'b0, idx};
		mag  = j[8] ? 16'd32767 : SineTable[j[7:0]];
		return quad[1] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage
`default_nettype wire

/* hdl/truncated_dft_low_pass_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// truncated_dft_low_pass_core
// Block low-pass filter: folds samples into the lowest DFT bins, then
// rebuilds the block from those bins with one shared complex multiplier.
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// input     | start, busy          | sample_in
// result    | strobe               | sample_out, last_out
// config    | wr_en                | wr_index, wr_data
//
// Each sample passes through the shared complex multiply-accumulate, which
// handles one bin per cycle over the nb kept bins, plus one pipeline drain.
// On the last sample of a block every result takes one setup, the issue run
// over the nb bins, drain, scale multiply, then the registered output.
// busy stays high throughout; reset at once clears bins and count, loads defaults.
// Results are shown on strobe for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module truncated_dft_low_pass_core import tdlp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] sample_in,
	output logic                    strobe,
	output logic signed [15:0]      sample_out,
	output logic                    last_out,
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [15:0]        wr_data
);

	typedef enum logic [2:0] {
		S_IDLE, S_IN_RUN, S_IN_DRAIN, S_OUT_SETUP,
		S_OUT_RUN, S_OUT_DRAIN, S_SCALE, S_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [6:0]  num_samples_q;
	logic [4:0]  num_bins_q;
	logic [15:0] phase_step_q;
	logic [15:0] inv_scale_q;

	// block state
	logic signed [BinW-1:0] bin_re_q [MaxBins];
	logic signed [BinW-1:0] bin_im_q [MaxBins];
	logic [6:0]  count_q;
	logic signed [15:0] x_q;
	logic [3:0]  k_q;
	logic [5:0]  m_q;
	logic [15:0] ph_q;
	logic [15:0] inc_q;
	logic signed [AccW-1:0] acc_q;

	// multiplier pipeline
	logic signed [ProdW-1:0] p1_s1;
	logic signed [ProdW-1:0] p2_s1;
	logic                    v_s1;
	logic                    in_s1;
	logic                    w_s1;
	logic [3:0]              k_s1;

	// scale partial products
	logic [38:0]        lo_s2;
	logic signed [39:0] hi_s2;

	// effective lengths
	logic [6:0] n_len;
	logic [4:0] nb;
	logic [3:0] k_last;
	always_comb begin
		if (num_samples_q < 7'd2) begin
			n_len = 7'd2;
		end else if (num_samples_q > 7'(MaxSamples)) begin
			n_len = 7'(MaxSamples);
		end else begin
			n_len = num_samples_q;
		end
		if (num_bins_q == 5'd0) begin
			nb = 5'd1;
		end else if (num_bins_q > 5'(MaxBins)) begin
			nb = 5'(MaxBins);
		end else begin
			nb = num_bins_q;
		end
	end
	assign k_last = 4'(nb - 5'd1);

	assign busy = (state_q != S_IDLE);

	// twiddles and shared multiplier operands
	logic signed [15:0]     cos_w;
	logic signed [15:0]     sin_w;
	logic signed [BinW-1:0] a1;
	logic signed [BinW-1:0] a2;
	logic                   in_mode;
	logic                   issue;
	assign cos_w   = sine_of(ph_q + 16'h4000);
	assign sin_w   = sine_of(ph_q);
	assign in_mode = (state_q == S_IN_RUN);
	assign issue   = (state_q == S_IN_RUN) || (state_q == S_OUT_RUN);
	assign a1      = in_mode ? BinW'(x_q) : bin_re_q[k_q];
	assign a2      = in_mode ? BinW'(x_q) : bin_im_q[k_q];

	// rounded bin updates and inverse term
	logic signed [ProdW-1:0] r1;
	logic signed [ProdW-1:0] r2;
	logic signed [ProdW:0]   term;
	logic signed [AccW-1:0]  term_w;
	assign r1     = (p1_s1 + ProdW'(1 << 14)) >>> 15;
	assign r2     = (p2_s1 + ProdW'(1 << 14)) >>> 15;
	assign term   = (ProdW+1)'(p1_s1) - (ProdW+1)'(p2_s1);
	assign term_w = w_s1 ? (AccW'(term) <<< 1) : AccW'(term);

	// scale combine, round and saturate
	logic signed [63:0] y_sum;
	logic signed [32:0] y_sh;
	logic signed [15:0] y_sat;
	always_comb begin
		y_sum = (64'(hi_s2) <<< 23) + $signed(64'(lo_s2)) + 64'sd1073741824;
		y_sh  = 33'(y_sum >>> 31);
		if (y_sh > 33'sd32767) begin
			y_sat = 16'sd32767;
		end else if (y_sh < -33'sd32768) begin
			y_sat = -16'sd32768;
		end else begin
			y_sat = 16'(y_sh);
		end
	end

	logic [6:0] count_inc;
	assign count_inc = count_q + 7'd1;

	// sequencer, datapath and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			num_samples_q <= 7'd64;
			num_bins_q    <= 5'd8;
			phase_step_q  <= 16'd1024;
			inv_scale_q   <= 16'd1024;
			count_q       <= '0;
			v_s1          <= 1'b0;
			strobe        <= 1'b0;
			last_out      <= 1'b0;
			for (int i = 0; i < MaxBins; i++) begin
				bin_re_q[i] <= '0;
				bin_im_q[i] <= '0;
			end
		end else begin
			strobe <= 1'b0;

			// configuration writes
			if (wr_en) begin
				case (wr_index)
					REG_NUM_SAMPLES: num_samples_q <= wr_data[6:0];
					REG_NUM_BINS:    num_bins_q    <= wr_data[4:0];
					REG_PHASE_STEP:  phase_step_q  <= wr_data;
					REG_INV_SCALE:   inv_scale_q   <= wr_data;
					default: ;
				endcase
			end

			// shared complex multiply, one bin per cycle
			v_s1  <= issue;
			in_s1 <= in_mode;
			w_s1  <= (k_q != 4'd0);
			k_s1  <= k_q;
			p1_s1 <= ProdW'(a1 * cos_w);
			p2_s1 <= ProdW'(a2 * sin_w);
			if (issue) begin
				ph_q <= ph_q + inc_q;
				k_q  <= k_q + 4'd1;
			end

			// accumulate stage
			if (v_s1) begin
				if (in_s1) begin
					bin_re_q[k_s1] <= bin_re_q[k_s1] + BinW'(r1);
					bin_im_q[k_s1] <= bin_im_q[k_s1] - BinW'(r2);
				end else begin
					acc_q <= acc_q + term_w;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						x_q     <= sample_in;
						inc_q   <= 16'(count_q * phase_step_q);
						ph_q    <= '0;
						k_q     <= '0;
						state_q <= S_IN_RUN;
					end
				end
				S_IN_RUN: begin
					if (k_q == k_last) begin
						state_q <= S_IN_DRAIN;
					end
				end
				S_IN_DRAIN: begin
					count_q <= count_inc;
					if (count_inc >= n_len) begin
						m_q     <= '0;
						state_q <= S_OUT_SETUP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT_SETUP: begin
					inc_q   <= 16'(m_q * phase_step_q);
					ph_q    <= '0;
					k_q     <= '0;
					acc_q   <= '0;
					state_q <= S_OUT_RUN;
				end
				S_OUT_RUN: begin
					if (k_q == k_last) begin
						state_q <= S_OUT_DRAIN;
					end
				end
				S_OUT_DRAIN: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					lo_s2   <= acc_q[22:0] * inv_scale_q;
					hi_s2   <= 40'($signed(acc_q[AccW-1:23]) * $signed({1'b0, inv_scale_q}));
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					strobe     <= 1'b1;
					sample_out <= y_sat;
					if ({1'b0, m_q} == n_len - 7'd1) begin
						last_out <= 1'b1;
						count_q  <= '0;
						for (int i = 0; i < MaxBins; i++) begin
							bin_re_q[i] <= '0;
							bin_im_q[i] <= '0;
						end
						state_q  <= S_IDLE;
					end else begin
						last_out <= 1'b0;
						m_q      <= m_q + 6'd1;
						state_q  <= S_OUT_SETUP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
